/* hdl/fhd_pkg.sv */
// Shared types and the fixed code tree for the fixed Huffman byte decoder.
`default_nettype none

package fhd_pkg;

   localparam int unsigned SymWidth   = 8;
   localparam int unsigned NodeWidth  = 4;
   localparam int unsigned MaxSymbols = 4;
   localparam int unsigned ByteBits   = 8;

   typedef logic [NodeWidth-1:0] node_type;
   typedef logic [SymWidth-1:0] sym_type;
   typedef logic [MaxSymbols-1:0][SymWidth-1:0] sym_arr_type;

   // One step of the tree: a leaf carries a symbol, otherwise value holds the next node.
   typedef struct packed {
      logic    leaf;
      sym_type value;
   } child_type;

   // Result of walking one whole byte through the tree.
   typedef struct packed {
      sym_arr_type syms;
      logic [1:0]  last_idx;
      logic        any;
      node_type    node;
   } walk_type;

   function automatic child_type fhd_leaf(input sym_type sym);
      child_type c;
      c.leaf  = 1'b1;
      c.value = sym;
      return c;
   endfunction

   function automatic child_type fhd_inner(input node_type n);
      child_type c;
      c.leaf  = 1'b0;
      c.value = {{(SymWidth-NodeWidth){1'b0}}, n};
      return c;
   endfunction

   // Child of an internal node for the bit just read.
   function automatic child_type fhd_child(input node_type node, input logic b);
      child_type c;
      unique case (node)
         4'd0:  c = b ? fhd_inner(4'd2)    : fhd_inner(4'd1);
         4'd1:  c = b ? fhd_inner(4'd3)    : fhd_leaf(8'd3);
         4'd2:  c = b ? fhd_inner(4'd5)    : fhd_inner(4'd4);
         4'd3:  c = b ? fhd_leaf(8'd1)     : fhd_leaf(8'd2);
         4'd4:  c = b ? fhd_leaf(8'd4)     : fhd_inner(4'd6);
         4'd5:  c = b ? fhd_leaf(8'd5)     : fhd_inner(4'd7);
         4'd6:  c = b ? fhd_leaf(8'd6)     : fhd_inner(4'd8);
         4'd7:  c = b ? fhd_leaf(8'd0)     : fhd_inner(4'd9);
         4'd8:  c = b ? fhd_inner(4'd10)   : fhd_inner(4'd11);
         4'd9:  c = b ? fhd_leaf(8'd7)     : fhd_inner(4'd12);
         4'd10: c = b ? fhd_leaf(8'd8)     : fhd_leaf(8'd11);
         4'd11: c = b ? fhd_leaf(8'hff)    : fhd_inner(4'd13);
         4'd12: c = b ? fhd_leaf(8'd19)    : fhd_leaf(8'd20);
         4'd13: c = b ? fhd_inner(4'd14)   : fhd_inner(4'd15);
         4'd14: c = b ? fhd_leaf(8'd13)    : fhd_leaf(8'd18);
         4'd15: c = b ? fhd_leaf(8'd9)     : fhd_leaf(8'd10);
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* hdl/fhd_walk.sv */
// Walks the eight bits of one code byte through the code tree.
`default_nettype none

module fhd_walk
   import fhd_pkg::*;
(
   input  wire logic [ByteBits-1:0] code_byte,
   input  wire logic                restart,
   input  wire node_type            node_start,
   output walk_type                 walk
);

   node_type    node;
   logic [2:0]  cnt;
   sym_arr_type syms;
   child_type   nxt;

   always_comb begin
      node = restart ? '0 : node_start;
      cnt  = '0;
      syms = '0;
      nxt  = '0;
      for (int i = 0; i < ByteBits; i++) begin
         nxt = fhd_child(node, code_byte[i]);
         if (nxt.leaf) begin
            // The shortest code is two bits, so a byte never completes more than four.
            if (cnt < 3'(MaxSymbols)) begin
               syms[cnt[1:0]] = nxt.value;
               cnt            = cnt + 3'd1;
            end
            node = '0;
         end else begin
            node = nxt.value[NodeWidth-1:0];
         end
      end
      walk.syms     = syms;
      walk.any      = (cnt != 3'd0);
      walk.last_idx = 2'(cnt - 3'd1);
      walk.node     = node;
   end

endmodule

`default_nettype wire

/* hdl/fhd_drain.sv */
// Result buffer that holds the symbols of one byte and hands them out one word a cycle while rsp_tready is high.
`default_nettype none

module fhd_drain
   import fhd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load_valid,
   input  wire walk_type walk,
   output logic         buf_free,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output logic [7:0]   rsp_tdata,   // [7:0] symbol
   output logic         rsp_tlast    // last_of_byte
);

   logic        valid_ff, valid_in;
   sym_arr_type syms_ff, syms_in;
   logic [1:0]  last_ff, last_in;
   logic [1:0]  idx_ff, idx_in;
   logic        fire, at_last;

   assign fire     = valid_ff && rsp_tready;
   assign at_last  = (idx_ff == last_ff);
   assign buf_free = !valid_ff || (fire && at_last);

   always_comb begin
      valid_in = valid_ff;
      syms_in  = syms_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load_valid && buf_free) begin
         valid_in = 1'b1;
         syms_in  = walk.syms;
         last_in  = walk.last_idx;
         idx_in   = '0;
      end else if (fire && at_last) begin
         valid_in = 1'b0;
      end else if (fire) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      syms_ff <= syms_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = syms_ff[idx_ff];
   assign rsp_tlast  = at_last;

endmodule

`default_nettype wire

/* hdl/fixed_huffman_byte_decoder_top.sv */
// Top level of the fixed Huffman byte decoder: input register, tree walk and result buffer.
`default_nettype none

// Decodes a stream of packed code bytes, bit 0 of each byte first, against a fixed
// seventeen-code prefix tree and emits one symbol word per completed code, with tlast on
// the last symbol completed within a byte. A byte that completes no code gives no word;
// its partial position carries into the next byte unless that byte has tuser (restart)
// set. A byte is registered, walked combinationally through all eight bits and its symbols
// loaded into the result buffer when that is free; the first symbol is offered from the
// buffer, so it passes the input register and then the buffer register before it leaves.
// The result channel moves one symbol a cycle while rsp_tready is high, so a byte that
// completes k codes (one to four) gives k words; bytes with no completed code give none.
// A new byte is taken while the previous byte's symbols are still being read out.

module fixed_huffman_byte_decoder_top
   import fhd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] code_byte
   input  wire logic       req_tuser,   // restart
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] symbol
   output logic            rsp_tlast    // last_of_byte
);

   logic                in_valid_ff, in_valid_in;
   logic [ByteBits-1:0] in_byte_ff, in_byte_in;
   logic                in_restart_ff, in_restart_in;
   node_type            node_ff, node_in;
   walk_type            walk;
   logic                buf_free;
   logic                consume;
   logic                req_fire;

   fhd_walk u_walk (
      .code_byte  (in_byte_ff),
      .restart    (in_restart_ff),
      .node_start (node_ff),
      .walk       (walk)
   );

   fhd_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff && walk.any),
      .walk       (walk),
      .buf_free   (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A byte with no completed code needs no room in the result buffer.
   assign consume    = in_valid_ff && (!walk.any || buf_free);
   assign req_tready = !in_valid_ff || consume;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      in_restart_in = in_restart_ff;
      node_in       = node_ff;
      if (consume) begin
         in_valid_in = 1'b0;
         node_in     = walk.node;
      end
      if (req_fire) begin
         in_valid_in   = 1'b1;
         in_byte_in    = req_tdata;
         in_restart_in = req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         node_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         node_ff     <= node_in;
      end
      in_byte_ff    <= in_byte_in;
      in_restart_ff <= in_restart_in;
   end

endmodule

`default_nettype wire
